// ===== rtl/core/ookt_pkg.sv =====
// ----------------------------------------------------------------------------
// ookt_pkg
// Shared types and constants for the on-off keying serial transmitter.
// ----------------------------------------------------------------------------
package ookt_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int CHAR_W   = 8;
   localparam int FRAME_W  = 4;
   localparam int GAP_W    = 4;
   localparam int PAIRS_W  = 5;
   localparam int KIND_W   = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_CHARS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_PERIODS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PREAMBLE_PAIRS = 2'd2;

   localparam logic [FRAME_W-1:0] FRAME_CHARS_RST    = 4'd5;
   localparam logic [GAP_W-1:0]   GAP_PERIODS_RST    = 4'd5;
   localparam logic [PAIRS_W-1:0] PREAMBLE_PAIRS_RST = 5'd8;
   localparam logic [PAIRS_W-1:0] MAX_PAIRS          = 5'd16;

   localparam logic [KIND_W-1:0] KIND_GAP      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PREAMBLE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DATA     = 2'd2;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_chars;
      logic [GAP_W-1:0]   gap_periods;
      logic [PAIRS_W-1:0] preamble_pairs;
   } cfg_type;

   // one classified request waiting for the sequencer
   typedef struct packed {
      logic [CHAR_W-1:0] char_byte;
      logic              sync;
   } entry_type;

   typedef enum logic [3:0] {
      PH_GAP    = 4'b0001,
      PH_PRE_HI = 4'b0010,
      PH_PRE_LO = 4'b0100,
      PH_DATA   = 4'b1000
   } phase_type;

endpackage

// ===== rtl/core/ookt_if.sv =====
// ----------------------------------------------------------------------------
// ookt_req_if / ookt_rsp_if
// Valid/ready channels for character requests and line symbols.
// ----------------------------------------------------------------------------
interface ookt_req_if;
   logic                        valid;
   logic                        ready;
   logic [ookt_pkg::CHAR_W-1:0] char_byte;

   modport source (output valid, output char_byte, input ready);
   modport sink   (input valid, input char_byte, output ready);
endinterface

interface ookt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        line_level;
   logic [ookt_pkg::KIND_W-1:0] symbol_kind;
   logic                        last;

   modport source (output valid, output line_level, output symbol_kind, output last,
                   input ready);
   modport sink   (input valid, input line_level, input symbol_kind, input last,
                   output ready);
endinterface

// ===== rtl/core/ook_preamble_serial_tx_core.sv =====
// The first symbol of a request passes through the queue and then the registered output stage.
// Each request sends its eight data bits, one symbol per cycle while rsp is ready; one that
// opens a group first sends gap_periods gap symbols and min(preamble_pairs, 16) preamble pairs.
// Requests are taken while a symbol waits, up to the queue depth ahead of the sequencer.
// Synchronous active-high reset clears the group position, queue and output stage and
// restores the registers to 5 / 5 / 8.
// ----------------------------------------------------------------------------
// ook_preamble_serial_tx_core
// On-off keying serial transmitter with gap and preamble framing.
// ----------------------------------------------------------------------------
module ook_preamble_serial_tx_core #(
   parameter int QUEUE_DEPTH = ookt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   ookt_req_if.sink                          req_chan,
   ookt_rsp_if.source                        rsp_chan,
   input  logic                              csr_write_en,
   input  logic [ookt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ookt_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   ookt_pkg::cfg_type   cfg_ff, cfg_in;
   logic                push, pop, q_full, q_nonempty;
   ookt_pkg::entry_type push_entry, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            ookt_pkg::CSR_FRAME_CHARS:
               cfg_in.frame_chars = csr_wdata[ookt_pkg::FRAME_W-1:0];
            ookt_pkg::CSR_GAP_PERIODS:
               cfg_in.gap_periods = csr_wdata[ookt_pkg::GAP_W-1:0];
            ookt_pkg::CSR_PREAMBLE_PAIRS:
               cfg_in.preamble_pairs = csr_wdata[ookt_pkg::PAIRS_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_chars    <= ookt_pkg::FRAME_CHARS_RST;
         cfg_ff.gap_periods    <= ookt_pkg::GAP_PERIODS_RST;
         cfg_ff.preamble_pairs <= ookt_pkg::PREAMBLE_PAIRS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ookt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   ookt_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .nonempty   (q_nonempty),
      .head       (q_head)
   );

   ookt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_nonempty (q_nonempty),
      .q_head     (q_head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ===== rtl/core/ookt_front.sv =====
// ----------------------------------------------------------------------------
// ookt_front
// Accepts character requests, tracks the group position and flags the ones
// that need a gap and preamble in front of them.
// ----------------------------------------------------------------------------
module ookt_front (
   input  logic                 clock,
   input  logic                 reset,
   ookt_req_if.sink             req_chan,
   input  ookt_pkg::cfg_type    cfg,
   input  logic                 q_full,
   output logic                 push,
   output ookt_pkg::entry_type  push_entry
);

   logic [ookt_pkg::FRAME_W-1:0] group_pos_ff, group_pos_in;
   logic [ookt_pkg::FRAME_W-1:0] group_size;
   logic [ookt_pkg::FRAME_W:0]   pos_inc;

   assign req_chan.ready = !q_full;
   assign push           = req_chan.valid && !q_full;

   assign push_entry.char_byte = req_chan.char_byte;
   assign push_entry.sync      = (group_pos_ff == '0);

   always_comb begin
      group_size = (cfg.frame_chars == '0) ? ookt_pkg::FRAME_W'(1) : cfg.frame_chars;
      pos_inc    = {1'b0, group_pos_ff} + 1'b1;
      group_pos_in = group_pos_ff;
      if (push) begin
         if (req_chan.char_byte == '0 || pos_inc >= {1'b0, group_size}) begin
            group_pos_in = '0;
         end else begin
            group_pos_in = pos_inc[ookt_pkg::FRAME_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_pos_ff <= '0;
      end else begin
         group_pos_ff <= group_pos_in;
      end
   end

endmodule

// ===== rtl/core/ookt_queue.sv =====
// ----------------------------------------------------------------------------
// ookt_queue
// Small register queue between the classifier and the symbol sequencer.
// ----------------------------------------------------------------------------
module ookt_queue #(
   parameter int DEPTH = ookt_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ookt_pkg::entry_type  push_entry,
   input  logic                 pop,
   output logic                 full,
   output logic                 nonempty,
   output ookt_pkg::entry_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   ookt_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign nonempty = (count_ff != '0);
   assign head     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/core/ookt_back.sv =====
// ----------------------------------------------------------------------------
// ookt_back
// Symbol sequencer: gap, preamble pairs and data bits, one symbol per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ookt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ookt_pkg::cfg_type    cfg,
   input  logic                 q_nonempty,
   input  ookt_pkg::entry_type  q_head,
   output logic                 pop,
   ookt_rsp_if.source           rsp_chan
);

   logic                          busy_ff, busy_in;
   ookt_pkg::phase_type           phase_ff, phase_in;
   logic [ookt_pkg::PAIRS_W-1:0]  cnt_ff, cnt_in;
   logic [ookt_pkg::CHAR_W-1:0]   char_ff, char_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          level_ff, level_in;
   logic [ookt_pkg::KIND_W-1:0]   kind_ff, kind_in;
   logic                          last_ff, last_in;

   logic [ookt_pkg::PAIRS_W-1:0]  pairs;
   ookt_pkg::phase_type           start_phase, cur_phase;
   logic [ookt_pkg::PAIRS_W-1:0]  cur_cnt, cnt_inc;
   logic [ookt_pkg::CHAR_W-1:0]   cur_char;
   logic                          advance, emit;

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.line_level  = level_ff;
   assign rsp_chan.symbol_kind = kind_ff;
   assign rsp_chan.last        = last_ff;

   always_comb begin
      pairs = (cfg.preamble_pairs > ookt_pkg::MAX_PAIRS) ? ookt_pkg::MAX_PAIRS
                                                         : cfg.preamble_pairs;
      if (!q_head.sync) begin
         start_phase = ookt_pkg::PH_DATA;
      end else if (cfg.gap_periods != '0) begin
         start_phase = ookt_pkg::PH_GAP;
      end else if (pairs != '0) begin
         start_phase = ookt_pkg::PH_PRE_HI;
      end else begin
         start_phase = ookt_pkg::PH_DATA;
      end

      cur_phase = busy_ff ? phase_ff : start_phase;
      cur_cnt   = busy_ff ? cnt_ff : '0;
      cur_char  = busy_ff ? char_ff : q_head.char_byte;
      cnt_inc   = cur_cnt + 1'b1;

      advance = !rsp_valid_ff || rsp_chan.ready;
      emit    = advance && (busy_ff || q_nonempty);
      pop     = emit && !busy_ff;

      busy_in  = busy_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      char_in  = char_ff;
      level_in = level_ff;
      kind_in  = kind_ff;
      last_in  = last_ff;
      rsp_valid_in = rsp_chan.ready ? 1'b0 : rsp_valid_ff;

      if (emit) begin
         rsp_valid_in = 1'b1;
         busy_in  = 1'b1;
         char_in  = cur_char;
         last_in  = 1'b0;
         phase_in = cur_phase;
         cnt_in   = cnt_inc;
         unique case (cur_phase)
            ookt_pkg::PH_GAP: begin
               level_in = 1'b0;
               kind_in  = ookt_pkg::KIND_GAP;
               if (cnt_inc == {1'b0, cfg.gap_periods}) begin
                  cnt_in   = '0;
                  phase_in = (pairs != '0) ? ookt_pkg::PH_PRE_HI : ookt_pkg::PH_DATA;
               end
            end
            ookt_pkg::PH_PRE_HI: begin
               level_in = 1'b1;
               kind_in  = ookt_pkg::KIND_PREAMBLE;
               cnt_in   = cur_cnt;
               phase_in = ookt_pkg::PH_PRE_LO;
            end
            ookt_pkg::PH_PRE_LO: begin
               level_in = 1'b0;
               kind_in  = ookt_pkg::KIND_PREAMBLE;
               if (cnt_inc == pairs) begin
                  cnt_in   = '0;
                  phase_in = ookt_pkg::PH_DATA;
               end else begin
                  phase_in = ookt_pkg::PH_PRE_HI;
               end
            end
            ookt_pkg::PH_DATA: begin
               level_in = cur_char[cur_cnt[2:0]];
               kind_in  = ookt_pkg::KIND_DATA;
               if (cur_cnt[2:0] == ookt_pkg::LAST_BIT) begin
                  last_in = 1'b1;
                  busy_in = 1'b0;
               end
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= ookt_pkg::PH_DATA;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff  <= char_in;
      level_ff <= level_in;
      kind_ff  <= kind_in;
      last_ff  <= last_in;
   end

endmodule

// ===== rtl/core/ookt_checker.sv =====
// ----------------------------------------------------------------------------
// ookt_checker
// Port-level checks on the symbol stream of the transmitter.
// ----------------------------------------------------------------------------
module ookt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_line_level,
   input logic [ookt_pkg::KIND_W-1:0] rsp_symbol_kind,
   input logic                        rsp_last
);

   // stalled symbol must hold
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_line_level)
         && $stable(rsp_symbol_kind) && $stable(rsp_last))
      else $error("rsp symbol changed while stalled");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_symbol_kind == ookt_pkg::KIND_DATA)
      else $error("last flag on non-data symbol");

   a_gap_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_symbol_kind == ookt_pkg::KIND_GAP |-> !rsp_line_level)
      else $error("gap symbol driven high");

   // after a data bit that is not last, the next symbol is also data
   a_data_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_symbol_kind == ookt_pkg::KIND_DATA && !rsp_last
         ##1 rsp_valid |-> rsp_symbol_kind == ookt_pkg::KIND_DATA)
      else $error("data run broken before last bit");

endmodule

bind ook_preamble_serial_tx_core ookt_checker u_ookt_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_line_level  (rsp_chan.line_level),
   .rsp_symbol_kind (rsp_chan.symbol_kind),
   .rsp_last        (rsp_chan.last)
);

// ===== dv/tb_ook_preamble_serial_tx_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ook_preamble_serial_tx_core
// Self-checking bench for the on-off keying serial transmitter. Characters go
// in with random bursts and gaps while the symbol side stalls on its own
// pattern. A local predictor builds the gap, preamble and data symbols of each
// accepted request, and every symbol that comes out is checked in order.
// ----------------------------------------------------------------------------
module tb_ook_preamble_serial_tx_core;

   localparam int LIMIT_CYCLES  = 1_000_000;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 8;
   localparam int RANDOM_PHASES = 10;
   localparam logic [ookt_pkg::CSR_IDX_W-1:0] CSR_UNUSED_IDX = 2'd3;

   typedef struct packed {
      logic                        line_level;
      logic [ookt_pkg::KIND_W-1:0] symbol_kind;
      logic                        last;
   } line_symbol_type;

   typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_type;

   logic                            clock;
   logic                            reset;
   logic                            csr_write_en;
   logic [ookt_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ookt_pkg::CSR_DATA_W-1:0] csr_wdata;

   ookt_req_if req_if ();
   ookt_rsp_if rsp_if ();

   ook_preamble_serial_tx_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   // predictor copy of the registers and group position
   logic [ookt_pkg::FRAME_W-1:0] tx_frame_chars;
   logic [ookt_pkg::GAP_W-1:0]   tx_gap_periods;
   logic [ookt_pkg::PAIRS_W-1:0] tx_preamble_pairs;
   logic [ookt_pkg::FRAME_W-1:0] tx_group_pos;

   line_symbol_type pending_symbols[$];
   int              err_count    = 0;
   int              cycle_count  = 0;
   int              burst_left   = 0;
   int              hold_reqs    = 0;
   int              hold_seen    = 0;
   int              stall_left   = 0;
   rx_mode_type     rx_mode      = RX_ALWAYS;
   int              rx_mode_left = 0;
   logic [7:0]      rx_pattern   = 8'hFF;
   int              rx_phase     = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void queue_char_symbols(input logic [ookt_pkg::CHAR_W-1:0] c);
      logic [ookt_pkg::FRAME_W-1:0] group;
      logic [ookt_pkg::PAIRS_W-1:0] pairs;
      group = (tx_frame_chars == 0) ? ookt_pkg::FRAME_W'(1) : tx_frame_chars;
      pairs = (tx_preamble_pairs > ookt_pkg::MAX_PAIRS) ? ookt_pkg::MAX_PAIRS
                                                        : tx_preamble_pairs;
      if (tx_group_pos == 0) begin
         for (int i = 0; i < tx_gap_periods; i++)
            pending_symbols.push_back('{1'b0, ookt_pkg::KIND_GAP, 1'b0});
         for (int i = 0; i < pairs; i++) begin
            pending_symbols.push_back('{1'b1, ookt_pkg::KIND_PREAMBLE, 1'b0});
            pending_symbols.push_back('{1'b0, ookt_pkg::KIND_PREAMBLE, 1'b0});
         end
      end
      for (int i = 0; i < ookt_pkg::CHAR_W; i++)
         pending_symbols.push_back('{c[i], ookt_pkg::KIND_DATA, i == ookt_pkg::CHAR_W - 1});
      if (c == 0) begin
         tx_group_pos = '0;
      end else begin
         tx_group_pos = tx_group_pos + 1'b1;
         if (tx_group_pos >= group)
            tx_group_pos = '0;
      end
   endfunction

   function automatic logic [ookt_pkg::CHAR_W-1:0] pick_char();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 2)
         return 8'h00;
      if (roll == 2)
         return 8'hFF;
      return ookt_pkg::CHAR_W'($urandom_range(1, 255));
   endfunction

   // called at a rising edge; returns at the edge where the request is taken
   task automatic push_char(input logic [ookt_pkg::CHAR_W-1:0] c);
      req_if.valid     <= 1'b1;
      req_if.char_byte <= c;
      do
         @(posedge clock);
      while (!req_if.ready);
      queue_char_symbols(c);
   endtask

   task automatic offer_char(input logic [ookt_pkg::CHAR_W-1:0] c);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      push_char(c);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_symbols.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ookt_pkg::CSR_IDX_W-1:0]  idx,
                            input logic [ookt_pkg::CSR_DATA_W-1:0] val);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      case (idx)
         ookt_pkg::CSR_FRAME_CHARS:    tx_frame_chars    = val[ookt_pkg::FRAME_W-1:0];
         ookt_pkg::CSR_GAP_PERIODS:    tx_gap_periods    = val[ookt_pkg::GAP_W-1:0];
         ookt_pkg::CSR_PREAMBLE_PAIRS: tx_preamble_pairs = val[ookt_pkg::PAIRS_W-1:0];
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_defaults();
      offer_char(8'hFF);
      offer_char(8'h00);
      offer_char(8'h01);
      offer_char(8'h80);
      offer_char(8'hA5);
      wait_drained();
   endtask

   task automatic test_register_extremes();
      // zero group size acts as one, zero gap and zero preamble leave only the data bits
      write_reg(ookt_pkg::CSR_FRAME_CHARS, 5'd0);
      write_reg(ookt_pkg::CSR_GAP_PERIODS, 5'd0);
      write_reg(ookt_pkg::CSR_PREAMBLE_PAIRS, 5'd0);
      offer_char(8'h5A);
      offer_char(8'hC3);
      wait_drained();
      // oversized preamble saturates
      write_reg(ookt_pkg::CSR_FRAME_CHARS, 5'd15);
      write_reg(ookt_pkg::CSR_GAP_PERIODS, 5'd15);
      write_reg(ookt_pkg::CSR_PREAMBLE_PAIRS, 5'd31);
      offer_char(8'h7E);
      offer_char(8'h00);
      wait_drained();
      write_reg(ookt_pkg::CSR_FRAME_CHARS, 5'd1);
      write_reg(ookt_pkg::CSR_GAP_PERIODS, 5'd1);
      write_reg(ookt_pkg::CSR_PREAMBLE_PAIRS, 5'd16);
      write_reg(CSR_UNUSED_IDX, 5'd31);
      offer_char(8'h81);
      offer_char(8'h42);
      wait_drained();
   endtask

   task automatic test_shrunk_group();
      write_reg(ookt_pkg::CSR_FRAME_CHARS, 5'd8);
      write_reg(ookt_pkg::CSR_GAP_PERIODS, 5'd2);
      write_reg(ookt_pkg::CSR_PREAMBLE_PAIRS, 5'd3);
      offer_char(8'h11);
      offer_char(8'h22);
      offer_char(8'h33);
      offer_char(8'h44);
      offer_char(8'h55);
      wait_drained();
      write_reg(ookt_pkg::CSR_FRAME_CHARS, 5'd3);
      offer_char(8'h66);
      offer_char(8'h77);
      wait_drained();
   endtask

   task automatic test_backpressure_fill();
      write_reg(ookt_pkg::CSR_FRAME_CHARS, 5'd4);
      write_reg(ookt_pkg::CSR_GAP_PERIODS, 5'd2);
      write_reg(ookt_pkg::CSR_PREAMBLE_PAIRS, 5'd2);
      hold_reqs <= hold_reqs + 1;
      for (int i = 0; i < 12; i++)
         push_char(pick_char());
      wait_drained();
   endtask

   task automatic test_random_streams();
      int n_items;
      logic [ookt_pkg::CSR_DATA_W-1:0] frame_val;
      logic [ookt_pkg::CSR_DATA_W-1:0] gap_val;
      logic [ookt_pkg::CSR_DATA_W-1:0] pairs_val;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         frame_val = ookt_pkg::CSR_DATA_W'($urandom_range(0, 15));
         gap_val   = ookt_pkg::CSR_DATA_W'($urandom_range(0, 15));
         pairs_val = ookt_pkg::CSR_DATA_W'($urandom_range(0, 31));
         if (p == 0) begin
            frame_val = 5'd0;
            gap_val   = 5'd0;
            pairs_val = 5'd0;
         end else if (p == 1) begin
            frame_val = 5'd15;
            gap_val   = 5'd15;
            pairs_val = 5'd31;
         end
         write_reg(ookt_pkg::CSR_FRAME_CHARS, frame_val);
         write_reg(ookt_pkg::CSR_GAP_PERIODS, gap_val);
         write_reg(ookt_pkg::CSR_PREAMBLE_PAIRS, pairs_val);
         n_items = $urandom_range(38, 46);
         for (int i = 0; i < n_items; i++)
            offer_char(pick_char());
         wait_drained();
      end
   endtask

   always @(posedge clock) begin : check_symbols
      line_symbol_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_symbols.size() == 0) begin
            $display("%0t: unexpected symbol level=%0b kind=%0d last=%0b", $time,
                     rsp_if.line_level, rsp_if.symbol_kind, rsp_if.last);
            err_count++;
         end else begin
            want = pending_symbols.pop_front();
            if (rsp_if.line_level !== want.line_level ||
                rsp_if.symbol_kind !== want.symbol_kind ||
                rsp_if.last !== want.last) begin
               $display("%0t: symbol mismatch, expected level=%0b kind=%0d last=%0b",
                        $time, want.line_level, want.symbol_kind, want.last);
               $display("%0t:                  actual   level=%0b kind=%0d last=%0b",
                        $time, rsp_if.line_level, rsp_if.symbol_kind, rsp_if.last);
               err_count++;
            end
         end
      end
   end

   task automatic rx_mode_ready(input logic r);
      rsp_if.ready <= r;
   endtask

   always @(posedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen  = hold_reqs;
         stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_type'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(16, 160);
            rx_pattern   = 8'($urandom_range(1, 255));
         end
         rx_mode_left--;
         rx_phase = (rx_phase + 1) % 8;
         case (rx_mode)
            RX_ALWAYS:  rx_mode_ready(1'b1);
            RX_COIN:    rx_mode_ready($urandom_range(0, 1) == 1);
            RX_PATTERN: rx_mode_ready(rx_pattern[rx_phase]);
            default:    rx_mode_ready($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_write_en      = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      req_if.valid      = 1'b0;
      req_if.char_byte  = '0;
      tx_frame_chars    = ookt_pkg::FRAME_CHARS_RST;
      tx_gap_periods    = ookt_pkg::GAP_PERIODS_RST;
      tx_preamble_pairs = ookt_pkg::PREAMBLE_PAIRS_RST;
      tx_group_pos      = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_shrunk_group();
      test_backpressure_fill();
      test_random_streams();

      wait_drained();
      if (err_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
